// ===== hdl/tdp_pkg.sv =====
// ----------------------------------------------------------------------------
// tdp_pkg: shared types for the trial-division prime tester
// Holds the status bundle that the bit-serial divider reports to the
// sequencer, and the fixed constants of the test.
// ----------------------------------------------------------------------------
package tdp_pkg;

    // The smallest prime, which is also the first divisor that is tried.
    localparam int FIRST_DIVISOR = 2;

    // Status of one finished division, as seen by the sequencer.
    typedef struct packed {
        logic done;        // one-cycle pulse after the last quotient bit
        logic rem_zero;    // the remainder is zero: the divisor divides exactly
        logic div_le_quo;  // divisor <= quotient, so the trial range goes on
    } div_status_t;

endpackage

// ===== hdl/trial_division_prime_test_core.sv =====
// ----------------------------------------------------------------------------
// trial_division_prime_test_core: trial-division primality tester
// Tests one unsigned number per input beat by dividing it by 2, 3, 4, ...
// while the divisor does not exceed the quotient, and stops at the first
// exact divisor. Zero and one are reported as not prime.
//
// Usage:
//   Input channel s_*: one beat carries the candidate in s_tdata.
//   Output channel m_*: one beat per input, the candidate echoed in m_tdata
//   and the prime flag in m_tuser.
//   Each trial is one pass of the bit-serial divider. A number n is tried
//   against the divisors 2, 3, ... up to k, where k is its smallest factor,
//   or floor(sqrt(n)) + 1 for a prime. Zero and one skip the divider and
//   are flagged as not prime without any trial.
//   s_tready is high only while no test is running; it stays high while a
//   finished result waits in the output register, so the next test can start.
//   If the receiver stalls and the output register is still full when a
//   test ends, the block holds that result until the register frees up.
//   Reset (aresetn low, synchronous) drops any test in progress and clears
//   the output valid.
// ----------------------------------------------------------------------------
module trial_division_prime_test_core #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // Input channel
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [((VALUE_WIDTH + 7) / 8) * 8-1:0] s_tdata,  // [VALUE_WIDTH-1:0] candidate
    // Output channel
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [((VALUE_WIDTH + 7) / 8) * 8-1:0] m_tdata,  // [VALUE_WIDTH-1:0] tested_value
    output logic [0:0]                            m_tuser   // [0] prime_flag
);
    import tdp_pkg::*;

    localparam int DATA_W = ((VALUE_WIDTH + 7) / 8) * 8;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TRIAL,
        ST_FINISH
    } state_t;

    state_t                 state_reg;
    logic                   start_reg;
    logic [VALUE_WIDTH-1:0] held_value_reg;
    logic [VALUE_WIDTH-1:0] trial_divisor_reg;
    logic                   prime_reg;
    logic                   m_tvalid_reg;
    logic [VALUE_WIDTH-1:0] out_value_reg;
    logic                   out_prime_reg;
    logic                   out_free;
    div_status_t            div_status;

    // Divider that tries one divisor per pass.
    tdp_divider #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_divider (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start_i    (start_reg),
        .dividend_i (held_value_reg),
        .divisor_i  (trial_divisor_reg),
        .status_o   (div_status)
    );

    assign out_free = !m_tvalid_reg || m_tready;

    // Sequencer: accept a beat, step the divisor, and hand off the result.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            start_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            start_reg <= 1'b0;
            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        held_value_reg    <= s_tdata[VALUE_WIDTH-1:0];
                        trial_divisor_reg <= VALUE_WIDTH'(FIRST_DIVISOR);
                        if (s_tdata[VALUE_WIDTH-1:0] < VALUE_WIDTH'(FIRST_DIVISOR)) begin
                            prime_reg <= 1'b0;
                            state_reg <= ST_FINISH;
                        end else begin
                            start_reg <= 1'b1;
                            state_reg <= ST_TRIAL;
                        end
                    end
                end
                ST_TRIAL: begin
                    if (div_status.done) begin
                        if (!div_status.div_le_quo) begin
                            // The divisor passed the square root: no factor.
                            prime_reg <= 1'b1;
                            state_reg <= ST_FINISH;
                        end else if (div_status.rem_zero) begin
                            prime_reg <= 1'b0;
                            state_reg <= ST_FINISH;
                        end else begin
                            trial_divisor_reg <= trial_divisor_reg + VALUE_WIDTH'(1);
                            start_reg         <= 1'b1;
                        end
                    end
                end
                ST_FINISH: begin
                    if (out_free) begin
                        out_value_reg <= held_value_reg;
                        out_prime_reg <= prime_reg;
                        m_tvalid_reg  <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = DATA_W'(out_value_reg);
    assign m_tuser  = out_prime_reg;

endmodule

// ===== hdl/tdp_divider.sv =====
// ----------------------------------------------------------------------------
// tdp_divider: bit-serial restoring divider
// Divides the dividend by the divisor one quotient bit per cycle, MSB first,
// and reports whether the remainder is zero and whether the divisor is not
// above the quotient. The divisor must stay stable while a division runs.
// ----------------------------------------------------------------------------
module tdp_divider #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start_i,
    input  logic [VALUE_WIDTH-1:0]   dividend_i,
    input  logic [VALUE_WIDTH-1:0]   divisor_i,
    output tdp_pkg::div_status_t     status_o
);
    import tdp_pkg::*;

    localparam int CNT_W = $clog2(VALUE_WIDTH);

    logic                   running_reg, running_next;
    logic                   done_reg, done_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [VALUE_WIDTH-1:0] quo_reg, quo_next;
    logic [VALUE_WIDTH-1:0] rem_reg, rem_next;
    logic [VALUE_WIDTH:0]   trial;
    logic [VALUE_WIDTH:0]   diff;

    // One restoring step: bring down the next dividend bit and try a subtract.
    assign trial = {rem_reg, quo_reg[VALUE_WIDTH-1]};
    assign diff  = trial - {1'b0, divisor_i};

    always_comb begin
        running_next = running_reg;
        done_next    = 1'b0;
        cnt_next     = cnt_reg;
        quo_next     = quo_reg;
        rem_next     = rem_reg;
        if (start_i) begin
            // The quotient register starts out holding the dividend and fills
            // with quotient bits from the bottom as the dividend shifts out.
            running_next = 1'b1;
            cnt_next     = CNT_W'(VALUE_WIDTH - 1);
            quo_next     = dividend_i;
            rem_next     = '0;
        end else if (running_reg) begin
            if (diff[VALUE_WIDTH]) begin
                rem_next = trial[VALUE_WIDTH-1:0];
                quo_next = {quo_reg[VALUE_WIDTH-2:0], 1'b0};
            end else begin
                rem_next = diff[VALUE_WIDTH-1:0];
                quo_next = {quo_reg[VALUE_WIDTH-2:0], 1'b1};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == '0) begin
                running_next = 1'b0;
                done_next    = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_reg <= 1'b0;
            done_reg    <= 1'b0;
            cnt_reg     <= '0;
        end else begin
            running_reg <= running_next;
            done_reg    <= done_next;
            cnt_reg     <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    // Results are read straight from the registers once done pulses.
    assign status_o.done       = done_reg;
    assign status_o.rem_zero   = (rem_reg == '0);
    assign status_o.div_le_quo = (divisor_i <= quo_reg);

endmodule

// ===== hdl/tdp_checker.sv =====
// ----------------------------------------------------------------------------
// tdp_checker: port-level checks for the trial-division prime tester
// Watches the top-level ports only and is bound to every instance of the
// top level.
// ----------------------------------------------------------------------------
module tdp_checker #(
    parameter int VALUE_WIDTH = 32
) (
    input logic                                   aclk,
    input logic                                   aresetn,
    input logic                                   s_tvalid,
    input logic                                   s_tready,
    input logic [((VALUE_WIDTH + 7) / 8) * 8-1:0] s_tdata,
    input logic                                   m_tvalid,
    input logic                                   m_tready,
    input logic [((VALUE_WIDTH + 7) / 8) * 8-1:0] m_tdata,
    input logic [0:0]                             m_tuser
);

    // A stalled output beat stays valid.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output beat dropped while stalled");

    // A stalled output beat keeps its payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("output payload changed while stalled");

    // Reset empties the output register.
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    // One test at a time: accepting a beat closes the input until it ends.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while a test runs");

    // Only values of two and above can be flagged as prime.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata[VALUE_WIDTH-1:1] != '0)
        else $error("zero or one flagged as prime");

endmodule

bind trial_division_prime_test_core tdp_checker #(
    .VALUE_WIDTH (VALUE_WIDTH)
) u_tdp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
